// ===== hw/rtl/aat_pkg.sv =====
// Shared widths, register indexes and saturation limits for the transformed
// box pipeline. No dependencies.
package aat_pkg;

  localparam int CoordW  = 32;
  localparam int MatW    = 16;
  localparam int ProdW   = CoordW + MatW;
  localparam int FracSh  = 12;
  localparam int TermW   = ProdW - FracSh;
  localparam int SumW    = TermW + 2;
  localparam int CfgIdxW = 3;
  localparam int NumAxes = 3;
  localparam int Latency = 5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } cfg_reg_t;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [MatW-1:0]   mat_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [TermW-1:0]  term_t;
  typedef logic signed [SumW-1:0]   sum_t;

  localparam sum_t SumMax = sum_t'(64'sh0000_0000_7FFF_FFFF);
  localparam sum_t SumMin = sum_t'(-64'sh0000_0000_8000_0000);

endpackage

// ===== hw/rtl/aabb_affine_transform_top.sv =====
// Transformed axis-aligned box pipeline: bounds of a configured box under a
// 3x3 linear map plus translation, with the centre. Depends on aat_pkg.
//
// Usage:
//   Configuration: write the original box (min x,y,z then max x,y,z, indexes
//   0..5) through cfg_valid/cfg_ready/cfg_index/cfg_data while the pipeline
//   is empty. cfg_ready is always high; indexes beyond five are dropped.
//   Items: present m00..m22 and shift_x/y/z with start; a transfer happens
//   at each edge where start is high and busy is low. busy is high only
//   while rst is held, so one item is taken every cycle.
//   Results: done pulses for one cycle with out_min_*, out_max_* and mid_*
//   once the item has passed the registered stages: 18 multipliers (16x32),
//   shift and min/max select, four-term sum, saturation, centre add.
//   Throughput is one item per cycle; results are in transfer order.
//   The receiver cannot stall, so nothing ever backs up.
//   Reset: synchronous rst clears the stage valid bits and the box
//   registers to zero; items in flight are dropped.
module aabb_affine_transform_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [15:0]         m00,
  input  logic signed [15:0]         m01,
  input  logic signed [15:0]         m02,
  input  logic signed [15:0]         m10,
  input  logic signed [15:0]         m11,
  input  logic signed [15:0]         m12,
  input  logic signed [15:0]         m20,
  input  logic signed [15:0]         m21,
  input  logic signed [15:0]         m22,
  input  logic signed [31:0]         shift_x,
  input  logic signed [31:0]         shift_y,
  input  logic signed [31:0]         shift_z,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [aat_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                cfg_data,
  output logic                       done,
  output logic signed [31:0]         out_min_x,
  output logic signed [31:0]         out_min_y,
  output logic signed [31:0]         out_min_z,
  output logic signed [31:0]         out_max_x,
  output logic signed [31:0]         out_max_y,
  output logic signed [31:0]         out_max_z,
  output logic signed [31:0]         mid_x,
  output logic signed [31:0]         mid_y,
  output logic signed [31:0]         mid_z
);
  import aat_pkg::*;

  coord_t omin [NumAxes];
  coord_t omax [NumAxes];

  mat_t   mat  [NumAxes][NumAxes];
  coord_t tin  [NumAxes];
  logic   accept;

  logic   v1, v2, v3, v4, v5;
  prod_t  p1   [NumAxes][NumAxes];
  prod_t  q1   [NumAxes][NumAxes];
  coord_t t1   [NumAxes];
  term_t  lo2  [NumAxes][NumAxes];
  term_t  hi2  [NumAxes][NumAxes];
  coord_t t2   [NumAxes];
  sum_t   lo3  [NumAxes];
  sum_t   hi3  [NumAxes];
  coord_t lo4  [NumAxes];
  coord_t hi4  [NumAxes];
  coord_t lo5  [NumAxes];
  coord_t hi5  [NumAxes];
  coord_t mid5 [NumAxes];

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign mat[0][0] = m00;
  assign mat[0][1] = m01;
  assign mat[0][2] = m02;
  assign mat[1][0] = m10;
  assign mat[1][1] = m11;
  assign mat[1][2] = m12;
  assign mat[2][0] = m20;
  assign mat[2][1] = m21;
  assign mat[2][2] = m22;
  assign tin[0]    = shift_x;
  assign tin[1]    = shift_y;
  assign tin[2]    = shift_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NumAxes; j++) begin
        omin[j] <= '0;
        omax[j] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_X: omin[0] <= cfg_data;
        REG_MIN_Y: omin[1] <= cfg_data;
        REG_MIN_Z: omin[2] <= cfg_data;
        REG_MAX_X: omax[0] <= cfg_data;
        REG_MAX_Y: omax[1] <= cfg_data;
        REG_MAX_Z: omax[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // multiply
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NumAxes; i++) begin
        t1[i] <= tin[i];
        for (int j = 0; j < NumAxes; j++) begin
          p1[i][j] <= prod_t'(mat[i][j]) * prod_t'(omin[j]);
          q1[i][j] <= prod_t'(mat[i][j]) * prod_t'(omax[j]);
        end
      end
    end
  end

  // scale and order
  always_ff @(posedge clk) begin
    if (v1) begin
      for (int i = 0; i < NumAxes; i++) begin
        t2[i] <= t1[i];
        for (int j = 0; j < NumAxes; j++) begin
          if (p1[i][j] < q1[i][j]) begin
            lo2[i][j] <= p1[i][j][ProdW-1:FracSh];
            hi2[i][j] <= q1[i][j][ProdW-1:FracSh];
          end else begin
            lo2[i][j] <= q1[i][j][ProdW-1:FracSh];
            hi2[i][j] <= p1[i][j][ProdW-1:FracSh];
          end
        end
      end
    end
  end

  // accumulate
  always_ff @(posedge clk) begin
    if (v2) begin
      for (int i = 0; i < NumAxes; i++) begin
        lo3[i] <= sum_t'(t2[i]) + sum_t'(lo2[i][0]) + sum_t'(lo2[i][1])
                + sum_t'(lo2[i][2]);
        hi3[i] <= sum_t'(t2[i]) + sum_t'(hi2[i][0]) + sum_t'(hi2[i][1])
                + sum_t'(hi2[i][2]);
      end
    end
  end

  // saturate
  always_ff @(posedge clk) begin
    if (v3) begin
      for (int i = 0; i < NumAxes; i++) begin
        if (lo3[i] > SumMax) begin
          lo4[i] <= SumMax[CoordW-1:0];
        end else if (lo3[i] < SumMin) begin
          lo4[i] <= SumMin[CoordW-1:0];
        end else begin
          lo4[i] <= lo3[i][CoordW-1:0];
        end
        if (hi3[i] > SumMax) begin
          hi4[i] <= SumMax[CoordW-1:0];
        end else if (hi3[i] < SumMin) begin
          hi4[i] <= SumMin[CoordW-1:0];
        end else begin
          hi4[i] <= hi3[i][CoordW-1:0];
        end
      end
    end
  end

  // centre
  always_ff @(posedge clk) begin
    if (v4) begin
      for (int i = 0; i < NumAxes; i++) begin
        lo5[i]  <= lo4[i];
        hi5[i]  <= hi4[i];
        mid5[i] <= coord_t'(((CoordW+1)'(lo4[i]) + (CoordW+1)'(hi4[i])) >>> 1);
      end
    end
  end

  assign done      = v5;
  assign out_min_x = lo5[0];
  assign out_min_y = lo5[1];
  assign out_min_z = lo5[2];
  assign out_max_x = hi5[0];
  assign out_max_y = hi5[1];
  assign out_max_z = hi5[2];
  assign mid_x     = mid5[0];
  assign mid_y     = mid5[1];
  assign mid_z     = mid5[2];

`ifndef SYNTHESIS
  a_done_follows_transfer: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, Latency))
    else $error("result without a matching transfer");

  a_transfer_gives_done: assert property (@(posedge clk) disable iff (rst)
    v4 |=> done)
    else $error("item lost in final stage");

  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_min_x <= out_max_x) && (out_min_y <= out_max_y)
             && (out_min_z <= out_max_z))
    else $error("minimum above maximum");

  a_mid_inside: assert property (@(posedge clk) disable iff (rst)
    done |-> (mid_x >= out_min_x) && (mid_x <= out_max_x)
             && (mid_y >= out_min_y) && (mid_y <= out_max_y)
             && (mid_z >= out_min_z) && (mid_z <= out_max_z))
    else $error("centre outside box");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the transformed box pipeline: directed rows, then random
// matrices over several box settings and sender idle patterns. Depends on aat_pkg.
module testbench;
  import aat_pkg::*;

  typedef logic [0:8][MatW-1:0]   mat_row_t;
  typedef logic [0:2][CoordW-1:0] vec3_t;
  typedef logic [0:5][CoordW-1:0] box_t;
  typedef logic [0:8][CoordW-1:0] res_t;

  typedef struct {
    int       box_sel;
    mat_row_t mat;
    vec3_t    shift;
    bit       typed;
    res_t     want;
  } stim_row_t;

  typedef enum int {
    BOX_WIDE,
    BOX_SPAN,
    BOX_INVERTED,
    BOX_CORNER,
    BOX_FLAT
  } box_kind_t;

  localparam logic [CfgIdxW-1:0] SpareIdxLo = 3'd6;
  localparam logic [CfgIdxW-1:0] SpareIdxHi = 3'd7;
  localparam logic [31:0] CMax    = 32'h7FFF_FFFF;
  localparam logic [31:0] CMin    = 32'h8000_0000;
  localparam logic [31:0] One     = 32'h0001_0000;
  localparam logic [31:0] NegOne  = 32'hFFFF_0000;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;
  localparam logic [15:0] MMax    = 16'h7FFF;
  localparam logic [15:0] MMin    = 16'h8000;
  localparam logic [15:0] MOne    = 16'h1000;
  localparam logic [15:0] MNegOne = 16'hF000;
  localparam coord_t SmallCoord   = 32'sh0010_0000;
  localparam mat_t   SmallMat     = 16'sh2000;
  localparam int StallLimit       = 2000;
  localparam int ItemsPerSeg      = 175;
  localparam int NumSegs          = 8;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [31:0] shift_x, shift_y, shift_z;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic done;
  logic signed [31:0] out_min_x, out_min_y, out_min_z;
  logic signed [31:0] out_max_x, out_max_y, out_max_z;
  logic signed [31:0] mid_x, mid_y, mid_z;

  coord_t    orig_box [6];
  res_t      pending_boxes [$];
  stim_row_t dir_rows [$];
  box_t      dir_boxes [5];
  int        idle_pct [4] = '{0, 74, 0, 9};
  string     field_name [9] = '{"out_min_x", "out_min_y", "out_min_z",
                                "out_max_x", "out_max_y", "out_max_z",
                                "mid_x", "mid_y", "mid_z"};
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int box_loads = 0;
  int idle_cycles = 0;

  aabb_affine_transform_top uut (.*);

  always #5 clk = ~clk;

  function automatic longint sat_coord(longint v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 64'sh0000_0000_7FFF_FFFF;
    if (v < -64'sh0000_0000_8000_0000) return -64'sh0000_0000_8000_0000;
    return v;
  endfunction

  function automatic res_t bound_box(mat_row_t m, vec3_t s);
    res_t r;
    longint lo, hi, mid, a, b, coef;
    coord_t sv;
    mat_t mv;
    for (int i = 0; i < NumAxes; i++) begin
      sv = s[i];
      lo = sv;
      hi = sv;
      for (int j = 0; j < NumAxes; j++) begin
        mv = m[i*3+j];
        coef = mv;
        a = (coef * longint'(orig_box[j])) >>> FracSh;
        b = (coef * longint'(orig_box[3+j])) >>> FracSh;
        if (a < b) begin
          lo += a;
          hi += b;
        end else begin
          lo += b;
          hi += a;
        end
      end
      lo = sat_coord(lo);
      hi = sat_coord(hi);
      mid = (lo + hi) >>> 1;
      r[i]   = lo[31:0];
      r[3+i] = hi[31:0];
      r[6+i] = mid[31:0];
    end
    return r;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(7))
      0, 1, 2, 3: return $urandom;
      4, 5: return coord_t'($urandom_range(2 * SmallCoord)) - SmallCoord;
      6: return $urandom_range(1) ? CMax : CMin;
      default: return '0;
    endcase
  endfunction

  function automatic mat_t rand_coef();
    case ($urandom_range(7))
      0, 1, 2, 3: return mat_t'($urandom);
      4, 5: return mat_t'($urandom_range(2 * SmallMat)) - SmallMat;
      6: return $urandom_range(1) ? MMax : MMin;
      default: return '0;
    endcase
  endfunction

  function automatic mat_row_t rand_mat();
    mat_row_t m;
    for (int k = 0; k < 9; k++) m[k] = rand_coef();
    return m;
  endfunction

  function automatic vec3_t rand_vec();
    vec3_t s;
    for (int k = 0; k < NumAxes; k++) s[k] = rand_coord();
    return s;
  endfunction

  function automatic box_t rand_box(box_kind_t kind);
    box_t b;
    coord_t lo, hi;
    for (int k = 0; k < NumAxes; k++) begin
      lo = coord_t'($urandom_range(2 * SmallCoord)) - SmallCoord;
      hi = lo + coord_t'($urandom_range(SmallCoord));
      case (kind)
        BOX_WIDE: begin
          b[k]   = $urandom;
          b[3+k] = $urandom;
        end
        BOX_SPAN: begin
          b[k]   = lo;
          b[3+k] = hi;
        end
        BOX_INVERTED: begin
          b[k]   = hi;
          b[3+k] = lo;
        end
        BOX_CORNER: begin
          b[k]   = $urandom_range(1) ? CMax : CMin;
          b[3+k] = $urandom_range(1) ? CMax : CMin;
        end
        default: begin
          b[k]   = rand_coord();
          b[3+k] = b[k];
        end
      endcase
    end
    return b;
  endfunction

  function automatic void add_dir(int box_sel, mat_row_t m, vec3_t s, bit typed, res_t want);
    stim_row_t row;
    row.box_sel = box_sel;
    row.mat     = m;
    row.shift   = s;
    row.typed   = typed;
    row.want    = want;
    dir_rows.push_back(row);
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_MAX_Z) orig_box[idx] = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_box(box_t b);
    for (int k = 0; k < 6; k++) write_reg(cfg_reg_t'(k), b[k]);
    write_reg(SpareIdxLo, $urandom);
    write_reg(SpareIdxHi, $urandom);
    box_loads++;
  endtask

  // drop start, wait for every result, then let the pipeline empty
  task automatic settle_pipe();
    @(negedge clk);
    start <= 1'b0;
    while (pending_boxes.size() > 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic send_item(mat_row_t m, vec3_t s, bit typed, res_t want);
    @(negedge clk);
    start   <= 1'b1;
    m00     <= m[0];
    m01     <= m[1];
    m02     <= m[2];
    m10     <= m[3];
    m11     <= m[4];
    m12     <= m[5];
    m20     <= m[6];
    m21     <= m[7];
    m22     <= m[8];
    shift_x <= s[0];
    shift_y <= s[1];
    shift_z <= s[2];
    do @(posedge clk); while (busy);
    pending_boxes.push_back(typed ? want : bound_box(m, s));
    items_sent++;
  endtask

  task automatic idle_gap(int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  always @(posedge clk) begin
    res_t got, want;
    if (!rst && done) begin
      got = {out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
             mid_x, mid_y, mid_z};
      if (pending_boxes.size() == 0) begin
        $error("result with no transfer outstanding");
        errors++;
      end else begin
        want = pending_boxes.pop_front();
        results_seen++;
        for (int k = 0; k < 9; k++) begin
          if (got[k] !== want[k]) begin
            $error("%s: expected %0d, actual %0d", field_name[k], $signed(want[k]),
                   $signed(got[k]));
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    {m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;
    {shift_x, shift_y, shift_z} = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (int k = 0; k < 6; k++) orig_box[k] = '0;

    dir_boxes[0] = {NegOne, NegOne, NegOne, One, One, One};
    dir_boxes[1] = {CMin, CMin, CMin, CMax, CMax, CMax};
    dir_boxes[2] = {32'h0002_0000, 32'h0000_8000, 32'h0010_0000,
                    32'hFFFE_0000, 32'hFFFF_8000, 32'hFFF0_0000};
    dir_boxes[3] = {32'h0001_8000, 32'hFFFE_8000, CMax,
                    32'h0001_8000, 32'hFFFE_8000, CMax};
    dir_boxes[4] = {AllOnes, AllOnes, AllOnes, 32'h1, 32'h1, 32'h1};

    // box at reset is a point at the origin: result is the shift itself
    add_dir(-1, {9{MMax}}, {CMax, CMin, 32'h0}, 1'b1,
            {3{CMax, CMin, 32'h0}});
    add_dir(-1, {9{MMin}}, {CMin, 32'h0, AllOnes}, 1'b1,
            {3{CMin, 32'h0, AllOnes}});
    add_dir(-1, {16'h1234, 16'hFEDC, 16'h0001, 16'h8001, 16'h7FFE, 16'h0F0F,
                 16'hF0F0, 16'h5555, 16'hAAAA},
            {32'h1234_5678, 32'h8765_4321, 32'h0000_0001}, 1'b1,
            {3{32'h1234_5678, 32'h8765_4321, 32'h0000_0001}});
    add_dir(0, {MOne, 16'h0, 16'h0, 16'h0, MOne, 16'h0, 16'h0, 16'h0, MOne},
            {3{32'h0}}, 1'b1,
            {NegOne, NegOne, NegOne, One, One, One, 32'h0, 32'h0, 32'h0});
    add_dir(-1, {MNegOne, 16'h0, 16'h0, 16'h0, MNegOne, 16'h0, 16'h0, 16'h0, MNegOne},
            {3{32'h0}}, 1'b0, '0);
    add_dir(-1, {9{MMax}}, {3{32'h0}}, 1'b0, '0);
    add_dir(-1, {9{MMin}}, {CMax, CMin, One}, 1'b0, '0);
    add_dir(-1, {16'h1000, 16'h2000, 16'h3000, 16'hF000, 16'hE000, 16'hD000,
                 16'h0800, 16'hF800, 16'h0001},
            {One, NegOne, 32'h0000_8000}, 1'b0, '0);
    add_dir(-1, {9{16'h0}}, {One, NegOne, CMax}, 1'b0, '0);
    add_dir(1, {9{MMax}}, {3{32'h0}}, 1'b1,
            {CMin, CMin, CMin, CMax, CMax, CMax, AllOnes, AllOnes, AllOnes});
    add_dir(-1, {9{MMin}}, {CMax, CMin, 32'h0}, 1'b1,
            {CMin, CMin, CMin, CMax, CMax, CMax, AllOnes, AllOnes, AllOnes});
    add_dir(-1, {9{16'h0}}, {CMax, CMin, 32'h0}, 1'b1,
            {3{CMax, CMin, 32'h0}});
    add_dir(-1, {16'h0001, 16'hFFFF, 16'h0002, 16'hFFFE, 16'h0001, 16'h0003,
                 16'hFFFD, 16'h0000, 16'hFFFF},
            {32'h0000_0003, AllOnes, 32'h8000_0001}, 1'b0, '0);
    add_dir(2, {MOne, 16'h0, 16'h0, 16'h0, MOne, 16'h0, 16'h0, 16'h0, MOne},
            {3{32'h0}}, 1'b0, '0);
    add_dir(-1, {16'hC000, 16'h3000, 16'hF123, 16'h0456, 16'h8000, 16'h7FFF,
                 16'hE000, 16'h1800, 16'hFFF0},
            {32'h0100_0000, 32'hFF00_0000, 32'h0}, 1'b0, '0);
    add_dir(3, {16'h1800, 16'hE800, 16'h0010, 16'hF000, 16'h7FFF, 16'h8000,
                16'h0001, 16'hFFFF, 16'h2000},
            {32'h0, One, NegOne}, 1'b0, '0);
    add_dir(-1, {9{MNegOne}}, {3{CMin}}, 1'b0, '0);
    add_dir(4, {16'h0001, 16'hFFFF, 16'h0FFF, 16'hF001, 16'h0002, 16'hFFFE,
                16'h1000, 16'h0000, 16'h0800},
            {3{32'h0}}, 1'b0, '0);
    add_dir(-1, {9{MMin}}, {32'h1, AllOnes, 32'h0}, 1'b0, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].box_sel >= 0) begin
        settle_pipe();
        load_box(dir_boxes[dir_rows[r].box_sel]);
      end
      send_item(dir_rows[r].mat, dir_rows[r].shift, dir_rows[r].typed, dir_rows[r].want);
    end

    for (int seg = 0; seg < NumSegs; seg++) begin
      settle_pipe();
      load_box(rand_box(box_kind_t'(seg % 5)));
      for (int n = 0; n < ItemsPerSeg; n++) begin
        send_item(rand_mat(), rand_vec(), 1'b0, '0);
        idle_gap(idle_pct[seg % 4]);
      end
    end

    settle_pipe();
    repeat (Latency + 4) @(posedge clk);
    $display("run covered %0d transfers and %0d checked results over %0d box settings,",
             items_sent, results_seen, box_loads);
    $display("with back-to-back, sparse and lightly gapped input phases");
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/aat_pkg.sv
hw/rtl/aabb_affine_transform_top.sv
verif/testbench.sv
